FILE: hdl/bcd_rtc_register_file_core_defines.svh
// Assertion macros used by the checker file of the RTC register file.
`ifndef BCD_RTC_REGISTER_FILE_CORE_DEFINES_SVH
`define BCD_RTC_REGISTER_FILE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define BCDRTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcdrtc check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define BCDRTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcdrtc check failed");

`endif

FILE: hdl/bcdrtc_pkg.sv
`timescale 1ns / 1ps

package bcdrtc_pkg;

    localparam int REG_COUNT = 32;
    localparam int ADDR_W    = 5;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_type_t;

    // Register map.
    localparam logic [ADDR_W-1:0] ISR_INDEX  = 5'h0e;
    localparam logic [ADDR_W-1:0] YEAR_INDEX = 5'd9;
    localparam logic [7:0]        YEAR_RESET = 8'd20;

    // BCD limits.
    localparam logic [3:0] DIGIT_MAX      = 4'd9;
    localparam logic [3:0] FRAC_TENS_MAX  = 4'd9;
    localparam logic [3:0] MINSEC_TENS_MAX = 4'd5;
    localparam logic [3:0] HOUR_TENS_MAX  = 4'd2;
    localparam logic [3:0] HOUR_UNITS_WRAP = 4'd3;

    // Number of time counters touched by a tick (ms, fraction, sec, min, hour).
    localparam int TIME_REGS = 5;

    typedef logic [TIME_REGS-1:0][7:0] time_bytes_t;

    // One operation handed from the input stage to the register bank.
    typedef struct packed {
        logic              fire;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } bcdrtc_op_t;

    // Advance a two-digit BCD counter. Bit 8 of the result flags a rollover.
    function automatic logic [8:0] bcd_advance(input logic [7:0] v,
                                               input logic [3:0] tens_max);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [8:0] res;
        lo = v[3:0];
        hi = v[7:4];
        if (hi > tens_max) begin
            res = 9'h100;
        end else if (lo < DIGIT_MAX) begin
            res = {1'b0, hi, lo + 4'd1};
        end else if (hi < tens_max) begin
            res = {1'b0, hi + 4'd1, 4'd0};
        end else begin
            res = 9'h100;
        end
        return res;
    endfunction

endpackage

FILE: hdl/bcdrtc_tick.sv
`timescale 1ns / 1ps

// Next values of the time counters for one tick, with the carry chain
// running from milliseconds up to hours.
module bcdrtc_tick (
    input  bcdrtc_pkg::time_bytes_t cnt_in,
    output bcdrtc_pkg::time_bytes_t cnt_out
);

    logic [3:0] ms_hi;
    logic       carry_ms;
    logic [8:0] adv_frac;
    logic [8:0] adv_sec;
    logic [8:0] adv_min;
    logic [8:0] adv_hour;
    logic       carry_frac;
    logic       carry_sec;
    logic       carry_min;
    logic       hour_wrap;

    // Counter advances, each assuming its carry-in is set.
    assign ms_hi    = cnt_in[0][7:4];
    assign carry_ms = (ms_hi >= bcdrtc_pkg::DIGIT_MAX);
    assign adv_frac = bcdrtc_pkg::bcd_advance(cnt_in[1], bcdrtc_pkg::FRAC_TENS_MAX);
    assign adv_sec  = bcdrtc_pkg::bcd_advance(cnt_in[2], bcdrtc_pkg::MINSEC_TENS_MAX);
    assign adv_min  = bcdrtc_pkg::bcd_advance(cnt_in[3], bcdrtc_pkg::MINSEC_TENS_MAX);
    assign adv_hour = bcdrtc_pkg::bcd_advance(cnt_in[4], bcdrtc_pkg::HOUR_TENS_MAX);

    // Carries ripple only while every lower counter rolls over.
    assign carry_frac = carry_ms & adv_frac[8];
    assign carry_sec  = carry_frac & adv_sec[8];
    assign carry_min  = carry_sec & adv_min[8];

    // Hours wrap from 23, and from any value past it.
    assign hour_wrap = (cnt_in[4][7:4] > bcdrtc_pkg::HOUR_TENS_MAX) ||
                       ((cnt_in[4][7:4] == bcdrtc_pkg::HOUR_TENS_MAX) &&
                        (cnt_in[4][3:0] >= bcdrtc_pkg::HOUR_UNITS_WRAP));

    always_comb
    begin
        cnt_out[0] = carry_ms ? 8'h00 : {ms_hi + 4'd1, cnt_in[0][3:0]};
        cnt_out[1] = carry_ms   ? adv_frac[7:0] : cnt_in[1];
        cnt_out[2] = carry_frac ? adv_sec[7:0]  : cnt_in[2];
        cnt_out[3] = carry_sec  ? adv_min[7:0]  : cnt_in[3];
        if (!carry_min) begin
            cnt_out[4] = cnt_in[4];
        end else if (hour_wrap) begin
            cnt_out[4] = 8'h00;
        end else begin
            cnt_out[4] = adv_hour[7:0];
        end
    end

endmodule

FILE: hdl/bcdrtc_bank.sv
`timescale 1ns / 1ps

// The 32-byte register bank. Applies one tick, read or write per cycle and
// returns the read byte for the same operation.
module bcdrtc_bank (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcdrtc_pkg::bcdrtc_op_t op,
    output logic [7:0]             rd_byte
);

    logic [7:0]              bank_reg [bcdrtc_pkg::REG_COUNT];
    bcdrtc_pkg::time_bytes_t time_cur;
    bcdrtc_pkg::time_bytes_t time_next;

    // Gather the time counters for the tick logic.
    always_comb
    begin
        for (int i = 0; i < bcdrtc_pkg::TIME_REGS; i++) begin
            time_cur[i] = bank_reg[i];
        end
    end

    bcdrtc_tick u_tick (
        .cnt_in  (time_cur),
        .cnt_out (time_next)
    );

    // Read data: the addressed byte on a read, zero otherwise.
    always_comb
    begin
        case (op.kind)
            bcdrtc_pkg::REQ_READ: rd_byte = bank_reg[op.addr];
            default:              rd_byte = 8'h00;
        endcase
    end

    // Register updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            // Everything clears except the year register.
            for (int i = 0; i < bcdrtc_pkg::REG_COUNT; i++) begin
                bank_reg[i] <= (i == int'(bcdrtc_pkg::YEAR_INDEX)) ?
                               bcdrtc_pkg::YEAR_RESET : 8'h00;
            end
        end else if (op.fire) begin
            case (op.kind)
                bcdrtc_pkg::REQ_TICK:
                begin
                    for (int i = 0; i < bcdrtc_pkg::TIME_REGS; i++) begin
                        bank_reg[i] <= time_next[i];
                    end
                    bank_reg[bcdrtc_pkg::ISR_INDEX] <=
                        bank_reg[bcdrtc_pkg::ISR_INDEX] | 8'h01;
                end
                bcdrtc_pkg::REQ_READ:
                begin
                    // Reading the interrupt status clears it.
                    if (op.addr == bcdrtc_pkg::ISR_INDEX) begin
                        bank_reg[bcdrtc_pkg::ISR_INDEX] <= 8'h00;
                    end
                end
                bcdrtc_pkg::REQ_WRITE:
                begin
                    bank_reg[op.addr] <= op.data;
                end
                default:
                begin
                    // Unused request kind: no change.
                end
            endcase
        end
    end

endmodule

FILE: hdl/bcd_rtc_register_file_core.sv
`timescale 1ns / 1ps

// Channel   | Dir | Fields (tdata / tuser, lowest bit first)
// s_axis    | in  | tdata: reg_addr[4:0], write_byte[12:5], zero pad; tuser: req_type
// m_axis    | out | tdata: read_byte[7:0]
//
// Each beat is registered on input, applied to the register bank once the
// output register is free or draining, and its result lands in the output
// register. One beat per cycle is sustained while m_axis_tready stays high.
// The input stage keeps taking beats while a result waits, until both the
// input and the output registers are full.
// rst_n clears the handshake state and loads the bank (year register = 20).
module bcd_rtc_register_file_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // reg_addr[4:0], write_byte[12:5], pad[15:13]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // read_byte[7:0]
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [1:0]                         in_kind_reg;
    logic [bcdrtc_pkg::ADDR_W-1:0]      in_addr_reg;
    logic [7:0]                         in_data_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [7:0]                         out_data_reg;
    logic                               s_fire;
    logic                               advance;
    logic [7:0]                         rd_byte;
    bcdrtc_pkg::bcdrtc_op_t             op;

    // The held beat moves on whenever the output register is free or draining.
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    assign in_valid_next  = s_fire | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~m_axis_tready);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            in_kind_reg <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[4:0];
            in_data_reg <= s_axis_tdata[12:5];
        end
    end

    // Operation applied to the bank.
    always_comb
    begin
        op.fire = advance;
        op.kind = in_kind_reg;
        op.addr = in_addr_reg;
        op.data = in_data_reg;
    end

    bcdrtc_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .rd_byte (rd_byte)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= rd_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: hdl/bcdrtc_checker.sv
`timescale 1ns / 1ps
`include "bcd_rtc_register_file_core_defines.svh"

// Port-level checks for the RTC register file.
module bcdrtc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled result beat stays put.
    `BCDRTC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Every accepted beat is followed by a valid result beat.
    `BCDRTC_ASSERT_IMP(a_beat_result, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid)

    // With the output register empty the input side never stalls.
    `BCDRTC_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind bcd_rtc_register_file_core bcdrtc_checker u_bcdrtc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
